// File: design/plc_pkg.sv
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants of the curve lookup unit
// Holds the table geometry, the command format that passes from the front end
// to the back end, and the range status codes.
// ----------------------------------------------------------------------------
package plc_pkg;

	// value and table geometry
	localparam int VW         = 32;                      // Q16.16 value width
	localparam int MAX_POINTS = 16;                      // breakpoint table depth
	localparam int PIDX_W     = $clog2(MAX_POINTS);      // table index width
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);  // points in use width
	localparam int CFG_W      = 5;                       // config register width
	localparam int STEP_W     = $clog2(VW);              // divider step counter width

	// command queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_EVAL  = 1'b1
	} cmd_kind_t;

	typedef enum logic [1:0] {
		ST_INSIDE = 2'd0,
		ST_BELOW  = 2'd1,
		ST_ABOVE  = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// one classified command; x carries the query for an evaluate
	typedef struct packed {
		cmd_kind_t               kind;
		logic [PIDX_W-1:0]       idx;
		logic signed [VW-1:0]    x;
		logic signed [VW-1:0]    y;
		logic [CNT_W-1:0]        cnt;
	} cmd_t;

	// queue status seen by the producer and the consumer
	typedef struct packed {
		logic not_empty;
		logic full;
	} q_stat_t;

endpackage

// File: design/plc_front.sv
// ----------------------------------------------------------------------------
// plc_front: input acceptance and classification
// Holds the points-in-use register, accepts input transactions while the
// command queue has room, and turns each one into a write or evaluate command.
// ----------------------------------------------------------------------------
module plc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       op,
	input  logic [3:0]                 point_index,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic signed [31:0]         query_x,
	input  logic                       cfg_we,
	input  logic [plc_pkg::CFG_W-1:0]  cfg_data,
	input  plc_pkg::q_stat_t           q_stat,
	output logic                       push,
	output plc_pkg::cmd_t              cmd
);
	import plc_pkg::*;

	logic [CFG_W-1:0] pts_q;
	logic [CNT_W-1:0] pts_sat;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pts_q <= '0;
		end else if (cfg_we) begin
			pts_q <= cfg_data;
		end
	end

	// counts beyond the table depth saturate
	assign pts_sat = (CNT_W'(pts_q) > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS)
	                                                    : CNT_W'(pts_q);

	// accept whenever the queue has a free slot
	assign item_stall = q_stat.full;
	assign push       = item_valid && !q_stat.full;

	// classify
	always_comb begin
		cmd.kind = op ? CMD_EVAL : CMD_WRITE;
		cmd.idx  = PIDX_W'(point_index);
		cmd.x    = op ? query_x : point_x;
		cmd.y    = point_y;
		cmd.cnt  = pts_sat;
	end

endmodule

// File: design/plc_queue.sv
// ----------------------------------------------------------------------------
// plc_queue: command queue between front and back end
// Small register FIFO; the head entry is presented without a bubble.
// ----------------------------------------------------------------------------
module plc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  plc_pkg::cmd_t     push_cmd,
	input  logic              pop,
	output plc_pkg::cmd_t     head,
	output plc_pkg::q_stat_t  q_stat
);
	import plc_pkg::*;

	cmd_t              slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_pop;

	assign q_stat.not_empty = (cnt_q != '0);
	assign q_stat.full      = (cnt_q == QCNT_W'(QDEPTH));
	assign do_pop           = pop && q_stat.not_empty;
	assign head             = slot_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: design/plc_back.sv
// ----------------------------------------------------------------------------
// plc_back: breakpoint table, scan and interpolation engine
// Executes queued commands in order: writes go to the table, evaluates scan
// the table one point a cycle, then multiply once and divide bit-serially.
// The result sits in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module plc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  plc_pkg::cmd_t                head,
	input  plc_pkg::q_stat_t             q_stat,
	output logic                         pop,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic signed [plc_pkg::VW-1:0] result_y,
	output plc_pkg::status_t             result_status
);
	import plc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DIFF,
		S_MUL,
		S_DIV,
		S_FIN,
		S_EMIT
	} state_t;

	state_t state_q;

	// breakpoint table
	logic signed [VW-1:0] mem_x [MAX_POINTS];
	logic signed [VW-1:0] mem_y [MAX_POINTS];
	logic signed [VW-1:0] rdx_q;
	logic signed [VW-1:0] rdy_q;
	logic [PIDX_W-1:0]    rd_addr;
	logic                 mem_we;

	// evaluation working registers
	logic signed [VW-1:0] q_q;
	logic [CNT_W-1:0]     n_q;
	logic [PIDX_W-1:0]    chk_q;
	logic signed [VW-1:0] x0_q, y0_q, x1_q, y1_q;
	logic [VW-1:0]        dq_q, dx_q, dy_q;
	logic                 neg_q;
	logic [VW-1:0]        rem_q, quo_q;
	logic [STEP_W-1:0]    step_q;
	logic signed [VW-1:0] res_y_q;
	status_t              res_st_q;

	logic                 x_lt, last, out_free;
	logic [VW:0]          trial, trial_sub;
	logic                 qbit;

	assign pop    = (state_q == S_IDLE) && q_stat.not_empty;
	assign mem_we = pop && (head.kind == CMD_WRITE);

	// next read address: first point at start, next point while scanning
	assign rd_addr = (state_q == S_SCAN) ? chk_q + 1'b1 : '0;

	// table write and registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_x[head.idx] <= head.x;
			mem_y[head.idx] <= head.y;
		end
		rdx_q <= mem_x[rd_addr];
		rdy_q <= mem_y[rd_addr];
	end

	// scan decisions on the point just read
	assign x_lt = rdx_q < q_q;
	assign last = (CNT_W'(chk_q) + CNT_W'(1)) == n_q;

	// one restoring division step
	assign trial     = {rem_q, quo_q[VW-1]};
	assign trial_sub = trial - {1'b0, dx_q};
	assign qbit      = (trial >= {1'b0, dx_q});

	assign out_free = !result_valid || !result_stall;

	// sequencer, working registers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			result_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop && head.kind == CMD_EVAL) begin
						q_q   <= head.x;
						n_q   <= head.cnt;
						chk_q <= '0;
						if (head.cnt == '0) begin
							res_y_q  <= '0;
							res_st_q <= ST_EMPTY;
							state_q  <= S_EMIT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (x_lt) begin
						if (last) begin
							res_y_q  <= rdy_q;
							res_st_q <= ST_ABOVE;
							state_q  <= S_EMIT;
						end else begin
							x0_q  <= rdx_q;
							y0_q  <= rdy_q;
							chk_q <= chk_q + 1'b1;
						end
					end else if (rdx_q == q_q) begin
						res_y_q  <= rdy_q;
						res_st_q <= ST_INSIDE;
						state_q  <= S_EMIT;
					end else if (chk_q == '0) begin
						res_y_q  <= rdy_q;
						res_st_q <= ST_BELOW;
						state_q  <= S_EMIT;
					end else begin
						x1_q    <= rdx_q;
						y1_q    <= rdy_q;
						state_q <= S_DIFF;
					end
				end
				S_DIFF: begin
					// x0 < q < x1, so all magnitudes fit the value width
					dq_q    <= VW'(q_q - x0_q);
					dx_q    <= VW'(x1_q - x0_q);
					neg_q   <= (y1_q < y0_q);
					dy_q    <= (y1_q < y0_q) ? VW'(y0_q - y1_q) : VW'(y1_q - y0_q);
					state_q <= S_MUL;
				end
				S_MUL: begin
					// high half is below dx since dq < dx
					{rem_q, quo_q} <= dq_q * dy_q;
					step_q         <= '0;
					state_q        <= S_DIV;
				end
				S_DIV: begin
					rem_q  <= qbit ? trial_sub[VW-1:0] : trial[VW-1:0];
					quo_q  <= {quo_q[VW-2:0], qbit};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(VW - 1)) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_y_q  <= neg_q ? y0_q - $signed(quo_q) : y0_q + $signed(quo_q);
					res_st_q <= ST_INSIDE;
					state_q  <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// output register: load a finished result, or clear once taken
			if (state_q == S_EMIT && out_free) begin
				result_valid  <= 1'b1;
				result_y      <= res_y_q;
				result_status <= res_st_q;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

endmodule

// File: design/piecewise_linear_curve_lookup_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_unit: piecewise-linear curve evaluator
// Table of breakpoints in signed Q16.16 with a scanning interpolation engine.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (item_valid/item_stall): op 0 writes point_x/point_y at
//   point_index; op 1 evaluates the curve at query_x. Points are expected in
//   ascending x. cfg_we/cfg_data set how many points are in use; write it
//   only while the unit is idle.
//   Result channel (result_valid/result_stall): one transaction per
//   evaluate, none per write, in input order.
// Execution:
//   A two-entry command queue decouples input from execution. A write is
//   handled by the back end in its idle state. An evaluate scans one point
//   per cycle (k points visited) and ends there on a clamp or exact hit; an
//   interpolation then goes through a multiply and the 32-step serial divider.
//   The back end finishes one evaluate before it takes the next command.
// Reset and stall:
//   arst_n clears the queue, the sequencer, the result valid and the point
//   count; table contents stay undefined until written. While result_stall
//   is high the result holds, the engine waits with its next result, and
//   input keeps flowing until the queue fills.
// ----------------------------------------------------------------------------
module piecewise_linear_curve_lookup_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic                       op,
	input  logic [3:0]                 point_index,
	input  logic signed [31:0]         point_x,
	input  logic signed [31:0]         point_y,
	input  logic signed [31:0]         query_x,
	input  logic                       cfg_we,
	input  logic [plc_pkg::CFG_W-1:0]  cfg_data,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic signed [31:0]         result_y,
	output logic [1:0]                 range_status
);
	import plc_pkg::*;

	cmd_t    push_cmd;
	cmd_t    head;
	q_stat_t q_stat;
	logic    push;
	logic    pop;
	status_t res_status;

	// front end: config register, accept and classify
	plc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.op          (op),
		.point_index (point_index),
		.point_x     (point_x),
		.point_y     (point_y),
		.query_x     (query_x),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.q_stat      (q_stat),
		.push        (push),
		.cmd         (push_cmd)
	);

	// command queue
	plc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	// back end: table, scan, interpolation, result register
	plc_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_stat        (q_stat),
		.pop           (pop),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.result_y      (result_y),
		.result_status (res_status)
	);

	assign range_status = res_status;

endmodule

// File: design/plc_checker.sv
// ----------------------------------------------------------------------------
// plc_checker: port-level checks of the curve lookup unit
// Watches the top-level ports only; attached by the bind below.
// ----------------------------------------------------------------------------
module plc_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [31:0] result_y,
	input logic [1:0]         range_status
);
	import plc_pkg::*;

	// a stalled result transaction stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result dropped while stalled");

	// and keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result_y) && $stable(range_status))
		else $error("result payload changed while stalled");

	// empty table reads as zero
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && range_status == ST_EMPTY |-> result_y == '0)
		else $error("empty-table result not zero");

	// nothing is offered while reset is held
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !result_valid)
		else $error("result valid during reset");

endmodule

bind piecewise_linear_curve_lookup_unit plc_checker u_plc_checker (.*);
